FILE: rtl/yaml_cls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaml_cls_pkg
// Shared constants and types for the YAML line classifier.
// ----------------------------------------------------------------------------
package yaml_cls_pkg;

    localparam int COUNT_BITS      = 16;
    localparam int MAX_KEY_LEN     = 32;
    localparam int MAX_VALUE_LEN   = 80;
    localparam int MAX_VALUE_WORDS = 12;
    localparam int MAX_ITEM_WORDS  = 4;
    localparam int WORD_CAP        = 15;
    localparam int RUN_CAP         = 255;
    localparam int LINE_CAP        = 7;
    localparam int KEY_W           = $clog2(MAX_KEY_LEN + 2);
    localparam int VAL_W           = $clog2(MAX_VALUE_LEN + 2);

    localparam logic [6:0] PCT_BASE = 7'd58;
    localparam logic [6:0] PCT_STEP = 7'd8;
    localparam logic [6:0] PCT_CAP  = 7'd92;

    typedef enum logic [1:0] {
        PH_KEY   = 2'd0,
        PH_VLEAD = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    // Per-line events handed from the line parser to the counters
    typedef struct packed {
        logic nonempty;
        logic doc;
        logic kv;
        logic block;
        logic list;
    } t_line_ev;

    function automatic logic f_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic f_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction
    function automatic logic f_lower(input logic [7:0] c);
        return c >= 8'h61 && c <= 8'h7a;
    endfunction
    function automatic logic f_alpha(input logic [7:0] c);
        return f_lower(c) || (c >= 8'h41 && c <= 8'h5a);
    endfunction
    function automatic logic f_key_char(input logic [7:0] c);
        return f_alpha(c) || f_digit(c) || c == 8'h5f || c == 8'h2d || c == 8'h2e;
    endfunction
    function automatic logic f_val_word(input logic [7:0] c);
        return f_key_char(c) || c == 8'h2f || c == 8'h22 || c == 8'h27 || c == 8'h40;
    endfunction
    function automatic logic f_punct(input logic [7:0] c);
        return c == 8'h2e || c == 8'h3f || c == 8'h21;
    endfunction

endpackage

FILE: rtl/yaml_cls_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaml_cls_line
// Per-byte line parser: tracks one line and reports its class at newline or at the last byte.
// ----------------------------------------------------------------------------
module yaml_cls_line (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [7:0]             i_char,
    input  logic                   i_last,
    output yaml_cls_pkg::t_line_ev o_ev
);

    localparam int KW = yaml_cls_pkg::KEY_W;
    localparam int VW = yaml_cls_pkg::VAL_W;

    // line state
    yaml_cls_pkg::t_phase r_phase, n_phase;
    logic [KW-1:0] r_klen, n_klen;
    logic [VW-1:0] r_vlen, n_vlen;
    logic [3:0]    r_words, n_words, r_vwords, n_vwords;
    logic [2:0]    r_llen, n_llen;
    logic [7:0]    r_run, n_run;
    logic r_dash_first, n_dash_first, r_list, n_list, r_dm_dash, n_dm_dash;
    logic r_dm_dot, n_dm_dot, r_colon0, n_colon0, r_s_tab, n_s_tab;
    logic r_s_inword, n_s_inword, r_s_sent, n_s_sent, r_prev_p, n_prev_p;
    logic r_key_bad, n_key_bad, r_key_alpha, n_key_alpha, r_key_lower, n_key_lower;
    logic r_key_d0, n_key_d0, r_val_bad, n_val_bad, r_val_inw, n_val_inw;
    logic r_val_sent, n_val_sent, r_run_tab, n_run_tab, r_run_sp0, n_run_sp0;

    // working copies after the whitespace / flush stage
    yaml_cls_pkg::t_phase w_phase;
    logic [KW-1:0] w_klen;
    logic [VW-1:0] w_vlen;
    logic [3:0]    w_words, w_vwords;
    logic w_s_inword, w_s_tab, w_s_sent, w_key_bad, w_val_bad, w_val_inw, w_val_sent;
    logic w_colon0, w_key_alpha, w_key_lower, w_key_d0;
    logic       do_subj, sent, is_nl, line_end, key_ok, val_ok, ok;
    logic [8:0] rsum;
    logic [KW+8:0] ksum;
    logic [VW+8:0] vsum;
    logic [9:0] llsum2;
    yaml_cls_pkg::t_line_ev ev;

    always_comb begin
        n_phase = r_phase; n_klen = r_klen; n_vlen = r_vlen; n_words = r_words;
        n_vwords = r_vwords; n_llen = r_llen; n_run = r_run;
        n_dash_first = r_dash_first; n_list = r_list; n_dm_dash = r_dm_dash;
        n_dm_dot = r_dm_dot; n_colon0 = r_colon0; n_s_tab = r_s_tab;
        n_s_inword = r_s_inword; n_s_sent = r_s_sent; n_prev_p = r_prev_p;
        n_key_bad = r_key_bad; n_key_alpha = r_key_alpha; n_key_lower = r_key_lower;
        n_key_d0 = r_key_d0; n_val_bad = r_val_bad; n_val_inw = r_val_inw;
        n_val_sent = r_val_sent; n_run_tab = r_run_tab; n_run_sp0 = r_run_sp0;
        do_subj = 1'b0;
        sent = r_prev_p && r_run_sp0;
        rsum = {1'b0, r_run} + 9'd1;
        ksum = '0; vsum = '0; llsum2 = '0;
        is_nl = i_char == 8'd10;

        w_phase = r_phase; w_klen = r_klen; w_vlen = r_vlen; w_words = r_words;
        w_vwords = r_vwords; w_s_inword = r_s_inword; w_s_tab = r_s_tab;
        w_s_sent = r_s_sent; w_key_bad = r_key_bad; w_val_bad = r_val_bad;
        w_val_inw = r_val_inw; w_val_sent = r_val_sent; w_colon0 = r_colon0;
        w_key_alpha = r_key_alpha; w_key_lower = r_key_lower; w_key_d0 = r_key_d0;

        if (!is_nl) begin
            if (yaml_cls_pkg::f_space(i_char)) begin
                if (r_llen != 3'd0) begin
                    if (r_run == 8'd0) begin
                        n_run_sp0 = i_char == 8'd32;
                        n_run_tab = i_char == 8'd9;
                    end else if (i_char == 8'd9) begin
                        n_run_tab = 1'b1;
                    end
                    n_run = (r_run == 8'(yaml_cls_pkg::RUN_CAP)) ? r_run : rsum[7:0];
                end
            end else if (r_llen == 3'd0) begin
                n_dash_first = i_char == 8'h2d;
                n_dm_dash = i_char == 8'h2d;
                n_dm_dot = i_char == 8'h2e;
                n_llen = 3'd1;
                do_subj = 1'b1;
            end else begin
                do_subj = 1'b1;
                n_dm_dash = r_dm_dash && r_run == 8'd0 && i_char == 8'h2d;
                n_dm_dot = r_dm_dot && r_run == 8'd0 && i_char == 8'h2e;
                if (r_run != 8'd0 && r_llen == 3'd1 && r_dash_first && r_run_sp0) begin
                    // list marker: restart subject on the item text
                    n_llen = 3'(yaml_cls_pkg::LINE_CAP);
                    n_list = 1'b1;
                    w_phase = yaml_cls_pkg::PH_KEY; w_klen = '0; w_vlen = '0;
                    w_words = '0; w_vwords = '0; w_s_inword = 1'b0; w_s_tab = 1'b0;
                    w_s_sent = 1'b0; w_key_bad = 1'b0; w_val_bad = 1'b0;
                    w_val_inw = 1'b0; w_val_sent = 1'b0; w_colon0 = 1'b0;
                    w_key_alpha = 1'b0; w_key_lower = 1'b0; w_key_d0 = 1'b0;
                end else begin
                    llsum2 = {7'd0, r_llen} + {2'b0, r_run} + 10'd1;
                    n_llen = (llsum2 > 10'(yaml_cls_pkg::LINE_CAP))
                           ? 3'(yaml_cls_pkg::LINE_CAP) : llsum2[2:0];
                    if (r_run != 8'd0) begin
                        // fold the pending run in as interior text
                        w_s_tab = r_s_tab || r_run_tab;
                        w_s_sent = r_s_sent || sent;
                        w_s_inword = 1'b0;
                        if (r_phase == yaml_cls_pkg::PH_KEY) begin
                            if (i_char != 8'h3a) begin
                                w_key_bad = 1'b1;
                                ksum = (KW+9)'(r_klen) + (KW+9)'(r_run);
                                w_klen = (ksum > (KW+9)'(yaml_cls_pkg::MAX_KEY_LEN + 1))
                                       ? KW'(yaml_cls_pkg::MAX_KEY_LEN + 1) : ksum[KW-1:0];
                            end
                        end else if (r_phase == yaml_cls_pkg::PH_VALUE) begin
                            w_val_bad = r_val_bad || r_run_tab;
                            w_val_sent = r_val_sent || sent;
                            vsum = (VW+9)'(r_vlen) + (VW+9)'(r_run);
                            w_vlen = (vsum > (VW+9)'(yaml_cls_pkg::MAX_VALUE_LEN + 1))
                                   ? VW'(yaml_cls_pkg::MAX_VALUE_LEN + 1) : vsum[VW-1:0];
                            w_val_inw = 1'b0;
                        end
                    end
                end
                n_run = 8'd0;
            end
        end

        if (do_subj) begin
            n_run = 8'd0;
            n_words = w_words;
            if (yaml_cls_pkg::f_key_char(i_char) && !w_s_inword
                && w_words != 4'(yaml_cls_pkg::WORD_CAP))
                n_words = w_words + 4'd1;
            n_s_inword = yaml_cls_pkg::f_key_char(i_char);
            n_s_tab = w_s_tab; n_s_sent = w_s_sent;
            n_phase = w_phase; n_klen = w_klen; n_vlen = w_vlen; n_vwords = w_vwords;
            n_key_bad = w_key_bad; n_val_bad = w_val_bad; n_val_inw = w_val_inw;
            n_val_sent = w_val_sent; n_colon0 = w_colon0; n_key_alpha = w_key_alpha;
            n_key_lower = w_key_lower; n_key_d0 = w_key_d0;
            if (w_phase == yaml_cls_pkg::PH_KEY) begin
                if (i_char == 8'h3a) begin
                    if (w_klen == '0) n_colon0 = 1'b1;
                    n_phase = yaml_cls_pkg::PH_VLEAD;
                end else begin
                    if (w_klen == '0 && yaml_cls_pkg::f_digit(i_char)) n_key_d0 = 1'b1;
                    if (!yaml_cls_pkg::f_key_char(i_char)) n_key_bad = 1'b1;
                    if (yaml_cls_pkg::f_alpha(i_char)) n_key_alpha = 1'b1;
                    if (yaml_cls_pkg::f_lower(i_char)) n_key_lower = 1'b1;
                    if (w_klen != KW'(yaml_cls_pkg::MAX_KEY_LEN + 1))
                        n_klen = w_klen + KW'(1);
                end
            end else begin
                n_phase = yaml_cls_pkg::PH_VALUE;
                if (i_char == 8'h7b || i_char == 8'h7d || i_char == 8'h3b)
                    n_val_bad = 1'b1;
                if (yaml_cls_pkg::f_val_word(i_char) && !w_val_inw
                    && w_vwords != 4'(yaml_cls_pkg::WORD_CAP))
                    n_vwords = w_vwords + 4'd1;
                n_val_inw = yaml_cls_pkg::f_val_word(i_char);
                if (w_vlen != VW'(yaml_cls_pkg::MAX_VALUE_LEN + 1))
                    n_vlen = w_vlen + VW'(1);
            end
            n_prev_p = yaml_cls_pkg::f_punct(i_char);
        end

        // line evaluation on the state after this byte
        line_end = is_nl || i_last;
        key_ok = n_klen >= KW'(1) && n_klen <= KW'(yaml_cls_pkg::MAX_KEY_LEN)
              && !n_key_bad && n_key_alpha && !n_key_d0
              && (n_key_lower || n_klen > KW'(4));
        val_ok = n_vlen >= VW'(1) && n_vlen <= VW'(yaml_cls_pkg::MAX_VALUE_LEN)
              && !n_val_bad && n_vwords <= 4'(yaml_cls_pkg::MAX_VALUE_WORDS) && !n_val_sent;
        ev = '0;
        ok = 1'b0;
        if (n_llen != 3'd0) begin
            ev.nonempty = 1'b1;
            if (n_llen == 3'd3 && (n_dm_dash || n_dm_dot)) begin
                ev.doc = 1'b1;
            end else if (n_list) begin
                if (n_s_tab)
                    ok = 1'b0;
                else if (n_phase == yaml_cls_pkg::PH_VALUE && !n_colon0)
                    ok = key_ok && val_ok;
                else
                    ok = n_words >= 4'd1 && n_words <= 4'(yaml_cls_pkg::MAX_ITEM_WORDS)
                      && !n_s_sent;
                ev.list = ok;
            end else if (!n_s_tab && n_phase != yaml_cls_pkg::PH_KEY && !n_colon0 && key_ok) begin
                if (n_phase == yaml_cls_pkg::PH_VLEAD) ev.block = 1'b1;
                else ev.kv = val_ok;
            end
        end
        if (!line_end) ev = '0;
    end

    assign o_ev = ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && (is_nl || i_last))) begin
            r_phase <= yaml_cls_pkg::PH_KEY; r_klen <= '0; r_vlen <= '0; r_words <= '0;
            r_vwords <= '0; r_llen <= '0; r_run <= '0; r_dash_first <= 1'b0;
            r_list <= 1'b0; r_dm_dash <= 1'b0; r_dm_dot <= 1'b0; r_colon0 <= 1'b0;
            r_s_tab <= 1'b0; r_s_inword <= 1'b0; r_s_sent <= 1'b0; r_prev_p <= 1'b0;
            r_key_bad <= 1'b0; r_key_alpha <= 1'b0; r_key_lower <= 1'b0;
            r_key_d0 <= 1'b0; r_val_bad <= 1'b0; r_val_inw <= 1'b0;
            r_val_sent <= 1'b0; r_run_tab <= 1'b0; r_run_sp0 <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase; r_klen <= n_klen; r_vlen <= n_vlen; r_words <= n_words;
            r_vwords <= n_vwords; r_llen <= n_llen; r_run <= n_run;
            r_dash_first <= n_dash_first; r_list <= n_list; r_dm_dash <= n_dm_dash;
            r_dm_dot <= n_dm_dot; r_colon0 <= n_colon0; r_s_tab <= n_s_tab;
            r_s_inword <= n_s_inword; r_s_sent <= n_s_sent; r_prev_p <= n_prev_p;
            r_key_bad <= n_key_bad; r_key_alpha <= n_key_alpha;
            r_key_lower <= n_key_lower; r_key_d0 <= n_key_d0; r_val_bad <= n_val_bad;
            r_val_inw <= n_val_inw; r_val_sent <= n_val_sent; r_run_tab <= n_run_tab;
            r_run_sp0 <= n_run_sp0;
        end
    end

endmodule

FILE: rtl/yaml_cls_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaml_cls_count
// Registered line events, saturating class counters and the final verdict.
// ----------------------------------------------------------------------------
module yaml_cls_count (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  yaml_cls_pkg::t_line_ev i_ev,
    input  logic                   i_last,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_busy,
    output logic [87:0]            o_data
);

    localparam int CB = yaml_cls_pkg::COUNT_BITS;

    // stage 1: registered event
    yaml_cls_pkg::t_line_ev r_ev;
    logic r_ev_v, r_ev_last;
    // counters (live across the lines of one text)
    logic [CB-1:0] r_ne, r_doc, r_kv, r_blk, r_lst;
    logic [CB-1:0] n_ne, n_doc, n_kv, n_blk, n_lst;
    // result register
    logic        r_out_v;
    logic [87:0] r_out;
    logic        yes, big;
    logic [CB+2:0] sig;
    logic [6:0]  pct;
    logic        stall;

    function automatic logic [CB-1:0] f_inc(input logic [CB-1:0] v, input logic e);
        return (e && v != {CB{1'b1}}) ? v + CB'(1) : v;
    endfunction

    assign stall = r_out_v && !i_out_ready;
    // one final beat may sit in stage 1 while another waits at the output
    assign o_busy = stall && r_ev_v && r_ev_last;

    always_comb begin
        n_ne  = f_inc(r_ne,  r_ev.nonempty);
        n_doc = f_inc(r_doc, r_ev.doc);
        n_kv  = f_inc(r_kv,  r_ev.kv);
        n_blk = f_inc(r_blk, r_ev.block);
        n_lst = f_inc(r_lst, r_ev.list);
        yes = n_ne != '0 && ((n_doc != '0 &&
              ((CB+2)'(n_kv) + (CB+2)'(n_blk) + (CB+2)'(n_lst)) >= (CB+2)'(2))
              || (n_blk != '0 && (n_lst != '0 || n_kv != '0)));
        sig = (CB+3)'(n_doc) + (CB+3)'(n_kv) + (CB+3)'(n_blk) + (CB+3)'(n_lst);
        big = sig >= (CB+3)'(5);
        pct = !yes ? 7'd0 : big ? yaml_cls_pkg::PCT_CAP
            : yaml_cls_pkg::PCT_BASE + yaml_cls_pkg::PCT_STEP * 7'(sig[2:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_v <= 1'b0; r_ev_last <= 1'b0; r_ev <= '0;
            r_ne <= '0; r_doc <= '0; r_kv <= '0; r_blk <= '0; r_lst <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (r_ev_v && r_ev_last && !stall) begin
                r_out_v <= 1'b1;
                r_out <= {n_lst[15:0], n_blk[15:0], n_kv[15:0],
                          n_doc[15:0], n_ne[15:0], pct, yes};
                r_ne <= '0; r_doc <= '0; r_kv <= '0; r_blk <= '0; r_lst <= '0;
            end else begin
                if (r_out_v && i_out_ready) r_out_v <= 1'b0;
                if (r_ev_v && !r_ev_last) begin
                    r_ne <= n_ne; r_doc <= n_doc; r_kv <= n_kv;
                    r_blk <= n_blk; r_lst <= n_lst;
                end
            end
            // stage 1 advances unless a final beat is blocked by the output
            if (!(r_ev_v && r_ev_last && stall)) begin
                r_ev_v <= i_en;
                r_ev_last <= i_last;
                r_ev <= i_ev;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_data = r_out;

endmodule

FILE: rtl/yaml_text_line_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaml_text_line_classifier
// Byte-stream YAML detector: classifies text lines and reports a verdict.
// ----------------------------------------------------------------------------
// Input channel s_axis: one text byte per beat in tdata, tlast on the final
// byte of a text. Output channel m_axis: one beat per text, sent after the
// tlast byte, carrying the verdict, a confidence percent and five counts.
// Each byte updates the line state; a line's class goes into the stage-1
// register, the counters fold it in, and the result register holds the beat.
// Throughput is one byte per cycle while s_axis_tready is high.
// Reset clears all line state and counters; no result is pending after it.
// When the receiver stalls the result stays in the output register and the
// next text keeps streaming in; s_axis_tready drops only when a second
// finished text would have nowhere to go.
// ----------------------------------------------------------------------------
module yaml_text_line_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [0] is_yaml, [7:1] confidence_pct,
                                        // [23:8] nonempty_lines, [39:24] doc_markers,
                                        // [55:40] key_value_lines,
                                        // [71:56] block_key_lines, [79:72] zero
    output logic [15:0] m_axis_tuser    // [15:0] list_lines
);

    logic                   acc, busy;
    yaml_cls_pkg::t_line_ev ev;
    logic [87:0]            res;

    assign s_axis_tready = !busy;
    assign acc = s_axis_tvalid && !busy;

    yaml_cls_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (acc),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_ev    (ev)
    );

    yaml_cls_count u_count (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (acc),
        .i_ev        (ev),
        .i_last      (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_busy      (busy),
        .o_data      (res)
    );

    assign m_axis_tdata = {8'd0, res[71:0]};
    assign m_axis_tuser = res[87:72];

endmodule

FILE: rtl/yaml_cls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaml_cls_sva
// Port-level checks for the YAML line classifier.
// ----------------------------------------------------------------------------
module yaml_cls_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // confidence is zero exactly when the verdict is no
    a_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[7:1] != 7'd0)))
        else $error("confidence disagrees with verdict");

    // confidence never exceeds its cap
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] <= 7'd92)
        else $error("confidence above cap");

    // ready only drops while a result waits
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled without pending result");

    // a result follows an accepted final byte when the output is free
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast && !m_axis_tvalid
        |=> ##1 m_axis_tvalid)
        else $error("missing result after final byte");

endmodule

bind yaml_text_line_classifier yaml_cls_sva u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
